>>> design/bounded_unique_key_set_unit_macros.svh
// Assertion macros for the key set datapath
`ifndef BOUNDED_UNIQUE_KEY_SET_UNIT_MACROS_SVH
`define BOUNDED_UNIQUE_KEY_SET_UNIT_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset
`define BUKS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset
`define BUKS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> design/buks_pkg.sv
// Shared constants and controller/datapath interface types for the key set
package buks_pkg;

    localparam int KEY_W         = 32;
    localparam int OP_W          = 2;
    localparam int CAP_W         = 7;
    localparam int CNT_OUT_W     = 7;
    localparam int MAX_DEPTH_DEF = 64;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;    // latch key, restart scan index
        logic scan;      // issue next scan read
        logic mv_rd;     // read last stored key
        logic wr_ins;    // append key, count up
        logic wr_mv;     // move last key into hit slot, count down
        logic out_load;  // load result register
        logic out_ok;    // success flag for the result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic ins_ok;    // room left under effective capacity
        logic nonempty;  // at least one key stored
        logic hit;       // compared entry matches key
        logic scan_end;  // compared entry is the last stored one
        logic out_free;  // result register can take a new result
    } t_sts;

endpackage

>>> design/bounded_unique_key_set_unit.sv
// Bounded unique key set: top level joining sequencer and datapath
//
// Input channel (i_in_valid / o_in_stall) carries an op and a 32-bit key:
// insert, lookup or remove. Each transfer yields exactly one result on the
// output channel (o_out_valid / i_out_stall): a success flag and the count
// of keys stored after the operation.
// One item is worked on at a time. The stored keys are scanned in order
// through the single read port of the key memory, one entry per cycle,
// with a registered read, until a match or the end of the stored keys.
// A remove that hits then moves the last key into the freed slot. Items
// refused at once (set full, set empty, unused op) skip the scan.
// o_in_stall is high from transfer until the result is loaded.
// The result sits in an output register: while the receiver stalls it holds
// and the next item is accepted and worked; that item waits for the register.
// i_cfg_we writes the capacity limit; write only while the block is idle.
// Synchronous active-low reset empties the set, sets the capacity to 64 and
// drops any pending result. Memory contents are not cleared.
module bounded_unique_key_set_unit #(
    parameter int MAX_DEPTH = buks_pkg::MAX_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [buks_pkg::OP_W-1:0]            i_op,
    input  logic signed [buks_pkg::KEY_W-1:0]    i_key,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_success,
    output logic [buks_pkg::CNT_OUT_W-1:0]       o_entry_count,
    input  logic                                 i_cfg_we,
    input  logic [buks_pkg::CAP_W-1:0]           i_cfg_wdata
);

    buks_pkg::t_cmd w_cmd;
    buks_pkg::t_sts w_sts;

    buks_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (o_in_stall)
    );

    buks_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key         (i_key),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_success     (o_success),
        .o_entry_count (o_entry_count)
    );

endmodule

>>> design/buks_ram.sv
// Generic simple dual-port RAM with registered read
module buks_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/buks_ctrl.sv
// Operation sequencer for the key set: scan, move and result steps
module buks_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic [buks_pkg::OP_W-1:0]  i_op,
    input  buks_pkg::t_sts             i_sts,
    output buks_pkg::t_cmd             o_cmd,
    output logic                       o_busy
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MV_RD,
        ST_MV_WR,
        ST_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [buks_pkg::OP_W-1:0]   r_op, n_op;
    logic                        r_ok, n_ok;

    // Next state and command decode
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_ok    = r_ok;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_op         = i_op;
                    n_ok         = 1'b0;
                    n_state      = ST_DONE;
                    case (i_op)
                        buks_pkg::OP_INSERT: begin
                            if (i_sts.ins_ok) begin
                                n_state = ST_SCAN;
                            end
                        end
                        buks_pkg::OP_LOOKUP, buks_pkg::OP_REMOVE: begin
                            if (i_sts.nonempty) begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SCAN: begin
                if (i_sts.hit) begin
                    case (r_op)
                        buks_pkg::OP_REMOVE: begin
                            n_ok    = 1'b1;
                            n_state = ST_MV_RD;
                        end
                        buks_pkg::OP_LOOKUP: begin
                            n_ok    = 1'b1;
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_ok    = 1'b0;
                            n_state = ST_DONE;
                        end
                    endcase
                end else if (i_sts.scan_end || !i_sts.nonempty) begin
                    // key absent or nothing stored: insert appends, others fail
                    if (r_op == buks_pkg::OP_INSERT) begin
                        o_cmd.wr_ins = 1'b1;
                        n_ok         = 1'b1;
                    end else begin
                        n_ok = 1'b0;
                    end
                    n_state = ST_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_MV_RD: begin
                o_cmd.mv_rd = 1'b1;
                n_state     = ST_MV_WR;
            end
            ST_MV_WR: begin
                o_cmd.wr_mv = 1'b1;
                n_state     = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        o_cmd.out_ok = r_ok;
    end

    // State and registered flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= buks_pkg::OP_INSERT;
            r_ok    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_ok    <= n_ok;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

>>> design/buks_dp.sv
// Key set datapath: key store, count, capacity, scan pipeline, result register
`include "bounded_unique_key_set_unit_macros.svh"

module buks_dp #(
    parameter int MAX_DEPTH = buks_pkg::MAX_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [buks_pkg::KEY_W-1:0]      i_key,
    input  logic                            i_cfg_we,
    input  logic [buks_pkg::CAP_W-1:0]      i_cfg_wdata,
    input  buks_pkg::t_cmd                  i_cmd,
    output buks_pkg::t_sts                  o_sts,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic                            o_success,
    output logic [buks_pkg::CNT_OUT_W-1:0]  o_entry_count
);

    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int CW = $clog2(MAX_DEPTH + 1);
    localparam int EW = (CW > buks_pkg::CAP_W) ? CW : buks_pkg::CAP_W;

    logic [buks_pkg::KEY_W-1:0]     r_key;
    logic [buks_pkg::CAP_W-1:0]     r_cap;
    logic [CW-1:0]                  r_count;
    logic [CW-1:0]                  r_idx;
    logic [CW-1:0]                  r_cmp_idx;
    logic                           r_rd_vld;
    logic [AW-1:0]                  r_slot;
    logic                           r_out_vld;
    logic                           r_ok;
    logic [buks_pkg::CNT_OUT_W-1:0] r_ocnt;

    logic [CW-1:0]                  w_last;
    logic [EW-1:0]                  w_cnt_e;
    logic [EW-1:0]                  w_cap_e;
    logic                           w_issue_ok;
    logic                           w_ram_we;
    logic [AW-1:0]                  w_waddr;
    logic [AW-1:0]                  w_raddr;
    logic [buks_pkg::KEY_W-1:0]     w_wdata;
    logic [buks_pkg::KEY_W-1:0]     w_rdata;

    assign w_last     = r_count - CW'(1);
    assign w_cnt_e    = EW'(r_count);
    assign w_cap_e    = EW'(r_cap);
    assign w_issue_ok = (r_idx < r_count);

    // Memory port selection
    assign w_ram_we = i_cmd.wr_ins | i_cmd.wr_mv;
    assign w_waddr  = i_cmd.wr_mv ? r_slot : r_count[AW-1:0];
    assign w_wdata  = i_cmd.wr_mv ? w_rdata : r_key;
    assign w_raddr  = i_cmd.mv_rd ? w_last[AW-1:0] : r_idx[AW-1:0];

    buks_ram #(
        .WIDTH (buks_pkg::KEY_W),
        .DEPTH (MAX_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Status back to the controller
    assign o_sts.ins_ok   = (w_cnt_e < w_cap_e) && (w_cnt_e < EW'(MAX_DEPTH));
    assign o_sts.nonempty = (r_count != '0);
    assign o_sts.hit      = r_rd_vld && (w_rdata == r_key);
    assign o_sts.scan_end = r_rd_vld && (r_cmp_idx == w_last);
    assign o_sts.out_free = !r_out_vld || !i_out_stall;

    // Payload registers: key, scan compare index, hit slot, result flag and count
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key <= i_key;
        end
        r_cmp_idx <= r_idx;
        if (o_sts.hit) begin
            r_slot <= r_cmp_idx[AW-1:0];
        end
        if (i_cmd.out_load) begin
            r_ok   <= i_cmd.out_ok;
            r_ocnt <= w_cnt_e[buks_pkg::CNT_OUT_W-1:0];
        end
    end

    // Control registers: capacity, count, scan index, read valid, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= buks_pkg::CAP_RESET;
            r_count   <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.wr_ins) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.wr_mv) begin
                r_count <= w_last;
            end
            if (i_cmd.accept) begin
                r_idx <= '0;
            end else if (i_cmd.scan && w_issue_ok) begin
                r_idx <= r_idx + CW'(1);
            end
            r_rd_vld <= i_cmd.scan && w_issue_ok;
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_success     = r_ok;
    assign o_entry_count = r_ocnt;

    `BUKS_ASSERT_IMP(a_count_bound, 1'b1, w_cnt_e <= EW'(MAX_DEPTH), "count above depth")
    `BUKS_ASSERT_IMP(a_one_write, w_ram_we, !(i_cmd.wr_ins && i_cmd.wr_mv), "two writes at once")
    `BUKS_ASSERT_NXT(a_ins_count, i_cmd.wr_ins, r_count == $past(r_count) + CW'(1), "insert count")
    `BUKS_ASSERT_IMP(a_no_overwrite, i_cmd.out_load, !r_out_vld || !i_out_stall, "result lost")

endmodule
